// ----- src/wrtr_pkg.sv -----
// Shared constants, types and helpers for the weighted row tile rectangle block.
// Used by wrtr_cfg, wrtr_div and weighted_row_tile_rect_core; depends on nothing.
package wrtr_pkg;

  localparam int MAX_ROWS = 6;
  localparam int NIB_W    = 4;
  localparam int PACK_W   = 24;
  localparam int COORD_W  = 12;
  localparam int CELL_W   = 7;
  localparam int ROW_W    = 3;
  localparam int WSUM_W   = 7;
  localparam int DVD_W    = 16;
  localparam int DCNT_W   = 3;
  localparam int REG_IDX_W = 2;

  localparam logic [PACK_W-1:0]  RST_CELL_COUNTS = PACK_W'(1);
  localparam logic [PACK_W-1:0]  RST_WEIGHTS     = PACK_W'(1);
  localparam logic [COORD_W-1:0] RST_WIDTH       = COORD_W'(320);
  localparam logic [COORD_W-1:0] RST_HEIGHT      = COORD_W'(240);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CELL_COUNTS = 2'd0,
    REG_WEIGHTS     = 2'd1,
    REG_WIDTH       = 2'd2,
    REG_HEIGHT      = 2'd3
  } reg_idx_t;

  // Row count and total weight of the current layout.
  typedef struct packed {
    logic [ROW_W-1:0]  nrows;
    logic [WSUM_W-1:0] wsum;
  } layout_sum_t;

  // Nibble of row r; rows beyond the supported count read as zero.
  function automatic logic [NIB_W-1:0] nibble(input logic [PACK_W-1:0] pk,
                                              input logic [ROW_W-1:0] r);
    logic [NIB_W-1:0] v;
    v = '0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      if (r == ROW_W'(i)) begin
        v = pk[i*NIB_W +: NIB_W];
      end
    end
    return v;
  endfunction

endpackage

// ----- src/weighted_row_tile_rect_core.sv -----
// Top level: row walk sequencer, output register and the assertions.
// Depends on wrtr_pkg, wrtr_cfg and wrtr_div.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, cell_index                 | into block
//   out     | out_valid, out_stall, rect_x/y/width/height,   | out of block
//           | found                                          |
//   config  | wr_en, wr_index, wr_data                       | into block
//
// Each row passed costs a walk step and a height division; the requested row adds
// height and width divisions, or only the width division on the last row, whose
// height needs no division. After the result the block returns to idle before it
// takes the next transaction. Reset is synchronous and restores the default
// one-cell layout. A new transaction is taken only when idle; a finished result
// waits in the output register meanwhile.
module weighted_row_tile_rect_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wrtr_pkg::CELL_W-1:0]         cell_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wrtr_pkg::COORD_W-1:0]        rect_x,
  output logic [wrtr_pkg::COORD_W-1:0]        rect_y,
  output logic [wrtr_pkg::COORD_W-1:0]        rect_width,
  output logic [wrtr_pkg::COORD_W-1:0]        rect_height,
  output logic                                found,
  input  logic                                wr_en,
  input  logic [wrtr_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [wrtr_pkg::PACK_W-1:0]         wr_data
);

  localparam int CoordW = wrtr_pkg::COORD_W;
  localparam int CellW  = wrtr_pkg::CELL_W;
  localparam int RowW   = wrtr_pkg::ROW_W;
  localparam int NibW   = wrtr_pkg::NIB_W;
  localparam int DvdW   = wrtr_pkg::DVD_W;
  localparam int WsumW  = wrtr_pkg::WSUM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_HDIV,
    ST_WDIV,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [CellW-1:0]       query_idx;
  logic [RowW-1:0]        row;
  logic [CellW-1:0]       first;
  logic [CoordW-1:0]      top;
  logic [CoordW-1:0]      rh;
  logic [CoordW-1:0]      res_x, res_y, res_w, res_h;
  logic                   res_found;

  logic [wrtr_pkg::PACK_W-1:0] cell_counts, weights;
  logic [CoordW-1:0]           width_r, height_r;
  wrtr_pkg::layout_sum_t       sum;

  logic                   div_start, div_busy, div_done;
  logic [DvdW-1:0]        div_dividend, div_q;
  logic [WsumW-1:0]       div_divisor;

  logic [NibW-1:0]        cells, weight;
  logic [CellW:0]         span_end;
  logic                   hit, end_of_list, last_row;
  logic [DvdW-1:0]        height_prod, x_full;
  logic [NibW-1:0]        col;
  logic [CoordW-1:0]      cwid, x_pos;

  wrtr_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .cell_counts (cell_counts),
    .weights     (weights),
    .width_r     (width_r),
    .height_r    (height_r),
    .sum         (sum)
  );

  wrtr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cells       = wrtr_pkg::nibble(cell_counts, row);
    weight      = wrtr_pkg::nibble(weights, row);
    span_end    = {1'b0, first} + (CellW + 1)'(cells);
    hit         = ({1'b0, query_idx} < span_end);
    end_of_list = (row >= sum.nrows);
    last_row    = (row == sum.nrows - RowW'(1));
    height_prod = DvdW'(height_r) * DvdW'(weight);
    col         = NibW'(query_idx - first);
    cwid        = div_q[CoordW-1:0];
    x_full      = DvdW'(col) * DvdW'(cwid);
    x_pos       = x_full[CoordW-1:0];
  end

  // The divider serves row heights first, then the width of the cell's row.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DvdW'(width_r);
    div_divisor  = WsumW'(cells);
    if (state == ST_WALK && !end_of_list) begin
      if (!last_row) begin
        div_start    = 1'b1;
        div_dividend = height_prod;
        div_divisor  = sum.wsum;
      end else if (hit) begin
        div_start = 1'b1;
      end
    end else if (state == ST_HDIV && div_done && hit) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            query_idx <= cell_index;
            row       <= '0;
            first     <= '0;
            top       <= '0;
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (end_of_list) begin
            res_x     <= '0;
            res_y     <= '0;
            res_w     <= '0;
            res_h     <= '0;
            res_found <= 1'b0;
            state     <= ST_FINISH;
          end else if (last_row) begin
            // The last row takes whatever height is left.
            rh <= height_r - top;
            if (hit) begin
              state <= ST_WDIV;
            end else begin
              row <= row + RowW'(1);
            end
          end else begin
            state <= ST_HDIV;
          end
        end
        ST_HDIV: begin
          if (div_done) begin
            rh <= div_q[CoordW-1:0];
            if (hit) begin
              state <= ST_WDIV;
            end else begin
              top   <= top + div_q[CoordW-1:0];
              first <= span_end[CellW-1:0];
              row   <= row + RowW'(1);
              state <= ST_WALK;
            end
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            res_x     <= x_pos;
            res_y     <= top;
            res_w     <= (col == cells - NibW'(1)) ? width_r - x_pos : cwid;
            res_h     <= rh;
            res_found <= 1'b1;
            state     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            rect_x      <= res_x;
            rect_y      <= res_y;
            rect_width  <= res_w;
            rect_height <= res_h;
            found       <= res_found;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> rect_x == '0 && rect_y == '0 &&
                            rect_width == '0 && rect_height == '0)
    else $error("missed cell reports a non-zero rectangle");

  a_accept_walks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_WALK)
    else $error("accepted transaction did not start the row walk");

  a_fits_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |->
      ({1'b0, rect_x} + {1'b0, rect_width}) == {1'b0, width_r} ||
      ({1'b0, rect_x} + {1'b0, rect_width}) <  {1'b0, width_r})
    else $error("cell extends past the screen width");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE || state == ST_FINISH |-> !div_busy)
    else $error("divider still busy outside a query");

endmodule

// ----- src/wrtr_cfg.sv -----
// Configuration registers and the derived layout summary (row count, weight sum).
// Depends on wrtr_pkg.
module wrtr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [wrtr_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [wrtr_pkg::PACK_W-1:0]         wr_data,
  output logic [wrtr_pkg::PACK_W-1:0]         cell_counts,
  output logic [wrtr_pkg::PACK_W-1:0]         weights,
  output logic [wrtr_pkg::COORD_W-1:0]        width_r,
  output logic [wrtr_pkg::COORD_W-1:0]        height_r,
  output wrtr_pkg::layout_sum_t               sum
);

  localparam int WsumW = wrtr_pkg::WSUM_W;
  localparam int NibW  = wrtr_pkg::NIB_W;
  localparam int RowW  = wrtr_pkg::ROW_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_counts <= wrtr_pkg::RST_CELL_COUNTS;
      weights     <= wrtr_pkg::RST_WEIGHTS;
      width_r     <= wrtr_pkg::RST_WIDTH;
      height_r    <= wrtr_pkg::RST_HEIGHT;
    end else if (wr_en) begin
      unique case (wrtr_pkg::reg_idx_t'(wr_index))
        wrtr_pkg::REG_CELL_COUNTS: cell_counts <= wr_data;
        wrtr_pkg::REG_WEIGHTS:     weights     <= wr_data;
        wrtr_pkg::REG_WIDTH:       width_r     <= wr_data[wrtr_pkg::COORD_W-1:0];
        wrtr_pkg::REG_HEIGHT:      height_r    <= wr_data[wrtr_pkg::COORD_W-1:0];
      endcase
    end
  end

  // The row list stops at the first row without cells.
  always_comb begin
    logic open_list;
    logic [NibW-1:0] cnt;
    open_list = 1'b1;
    sum.nrows = '0;
    sum.wsum  = '0;
    for (int r = 0; r < wrtr_pkg::MAX_ROWS; r++) begin
      cnt = wrtr_pkg::nibble(cell_counts, RowW'(r));
      if (open_list && cnt != '0) begin
        sum.nrows = sum.nrows + RowW'(1);
        sum.wsum  = sum.wsum + WsumW'(wrtr_pkg::nibble(weights, RowW'(r)));
      end else begin
        open_list = 1'b0;
      end
    end
    if (sum.wsum == '0) begin
      sum.wsum = WsumW'(1);
    end
  end

endmodule

// ----- src/wrtr_div.sv -----
// Shared iterative restoring divider, two quotient bits per cycle.
// Depends on wrtr_pkg.
module wrtr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wrtr_pkg::DVD_W-1:0]    dividend,
  input  logic [wrtr_pkg::WSUM_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [wrtr_pkg::DVD_W-1:0]    quotient
);

  localparam int DvdW = wrtr_pkg::DVD_W;
  localparam int RemW = wrtr_pkg::WSUM_W;

  logic [RemW-1:0]               rem;
  logic [RemW-1:0]               dvs;
  logic [RemW-1:0]               rem_mid, rem_next;
  logic [DvdW-1:0]               quo_mid, quo_next;
  logic [wrtr_pkg::DCNT_W-1:0]   cnt;

  // The divisor is captured at start, so the caller may change its inputs meanwhile.
  always_comb begin
    logic [RemW:0] t0, t1, dv;
    logic ge0, ge1;
    dv  = {1'b0, dvs};
    t0  = {rem, quotient[DvdW-1]};
    ge0 = (t0 >= dv);
    rem_mid = ge0 ? RemW'(t0 - dv) : t0[RemW-1:0];
    quo_mid = {quotient[DvdW-2:0], ge0};
    t1  = {rem_mid, quo_mid[DvdW-1]};
    ge1 = (t1 >= dv);
    rem_next = ge1 ? RemW'(t1 - dv) : t1[RemW-1:0];
    quo_next = {quo_mid[DvdW-2:0], ge1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= quo_next;
      rem      <= rem_next;
    end
  end

endmodule

// ----- dv/weighted_row_tile_rect_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for weighted_row_tile_rect_core: directed and random layouts and queries,
// each rectangle checked against an in-bench layout model held in a small scoreboard.
// Depends on wrtr_pkg and the weighted_row_tile_rect_core RTL.
module weighted_row_tile_rect_core_test;

  localparam int CELL_W    = wrtr_pkg::CELL_W;
  localparam int COORD_W   = wrtr_pkg::COORD_W;
  localparam int PACK_W    = wrtr_pkg::PACK_W;
  localparam int NIB_W     = wrtr_pkg::NIB_W;
  localparam int MAX_ROWS  = wrtr_pkg::MAX_ROWS;
  localparam int REG_IDX_W = wrtr_pkg::REG_IDX_W;

  localparam int QUERY_COUNT = 2000;
  localparam int CALM_TAIL   = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_no;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] wd;
    logic [COORD_W-1:0] ht;
    logic               hit;
  } cell_rect_t;

  class rect_scoreboard;
    logic [PACK_W-1:0]  counts;
    logic [PACK_W-1:0]  weights;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    cell_rect_t expected_rects[$];
    int errors;
    int queries;
    int hits;

    function new();
      counts  = 24'd1;
      weights = 24'd1;
      width   = 12'd320;
      height  = 12'd240;
      errors  = 0;
      queries = 0;
      hits    = 0;
    endfunction

    function void set_reg(input wrtr_pkg::reg_idx_t idx, input logic [PACK_W-1:0] data);
      case (idx)
        wrtr_pkg::REG_CELL_COUNTS: counts = data;
        wrtr_pkg::REG_WEIGHTS:     weights = data;
        wrtr_pkg::REG_WIDTH:       width = data[COORD_W-1:0];
        wrtr_pkg::REG_HEIGHT:      height = data[COORD_W-1:0];
        default: ;
      endcase
    endfunction

    // Number of cells in the current layout; the row list stops at the first empty row.
    function int cell_total();
      int sum;
      int r;
      sum = 0;
      r = 0;
      while (r < MAX_ROWS && counts[r*NIB_W +: NIB_W] != 0) begin
        sum += counts[r*NIB_W +: NIB_W];
        r++;
      end
      return sum;
    endfunction

    function cell_rect_t locate_cell(input logic [CELL_W-1:0] cell_no);
      cell_rect_t res;
      int unsigned wsum, nrows, first, top, cells, rh, c, cwid, px, cw;
      bit done;
      res = '0;
      res.cell_no = cell_no;
      wsum = 0;
      nrows = 0;
      first = 0;
      top = 0;
      done = 0;
      while (nrows < MAX_ROWS && counts[nrows*NIB_W +: NIB_W] != 0) begin
        wsum += weights[nrows*NIB_W +: NIB_W];
        nrows++;
      end
      // An all-zero weight sum is treated as one, so the last row gets the full height.
      if (wsum == 0) wsum = 1;
      for (int r = 0; r < nrows; r++) begin
        cells = counts[r*NIB_W +: NIB_W];
        if (r == nrows - 1) rh = height - top;
        else rh = height * weights[r*NIB_W +: NIB_W] / wsum;
        if (!done && cell_no < first + cells) begin
          c    = cell_no - first;
          cwid = width / cells;
          px   = c * cwid;
          cw   = (c == cells - 1) ? width - px : cwid;
          res.x   = COORD_W'(px);
          res.y   = COORD_W'(top);
          res.wd  = COORD_W'(cw);
          res.ht  = COORD_W'(rh);
          res.hit = 1'b1;
          done = 1;
        end
        first += cells;
        top += rh;
      end
      return res;
    endfunction

    function void note_query(input logic [CELL_W-1:0] cell_no);
      cell_rect_t want;
      want = locate_cell(cell_no);
      expected_rects.push_back(want);
      queries++;
      if (want.hit) hits++;
    endfunction

    function int outstanding();
      return expected_rects.size();
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_rect(input cell_rect_t got);
      cell_rect_t want;
      if (expected_rects.size() == 0) begin
        report_mismatch($sformatf(
          "result with no query outstanding: x=%0d y=%0d w=%0d h=%0d found=%0b",
          got.x, got.y, got.wd, got.ht, got.hit));
      end else begin
        want = expected_rects.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.wd !== want.wd ||
            got.ht !== want.ht || got.hit !== want.hit) begin
          report_mismatch($sformatf(
            {"cell %0d: got x=%0d y=%0d w=%0d h=%0d found=%0b, ",
             "want x=%0d y=%0d w=%0d h=%0d found=%0b"},
            want.cell_no, got.x, got.y, got.wd, got.ht, got.hit,
            want.x, want.y, want.wd, want.ht, want.hit));
        end
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CELL_W-1:0]    cell_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   rect_x;
  logic [COORD_W-1:0]   rect_y;
  logic [COORD_W-1:0]   rect_width;
  logic [COORD_W-1:0]   rect_height;
  logic                 found;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [PACK_W-1:0]    wr_data = '0;

  rect_scoreboard sb;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;
  int layouts = 0;

  weighted_row_tile_rect_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cell_index  (cell_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .found       (found),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check each transaction taken at this edge, then decide the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_rect('{cell_no: '0, x: rect_x, y: rect_y, wd: rect_width, ht: rect_height,
                      hit: found});
    end
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
    out_stall <= (stall_left > 0);
  end

  // Writes the registers selected by mask back to back; wr_en is lowered once at the end.
  task automatic load_layout(input logic [PACK_W-1:0] cc, input logic [PACK_W-1:0] wt,
                             input logic [PACK_W-1:0] wd, input logic [PACK_W-1:0] ht,
                             input logic [3:0] mask);
    wrtr_pkg::reg_idx_t order [4];
    logic [PACK_W-1:0]  data  [4];
    order = '{wrtr_pkg::REG_CELL_COUNTS, wrtr_pkg::REG_WEIGHTS,
              wrtr_pkg::REG_WIDTH, wrtr_pkg::REG_HEIGHT};
    data  = '{cc, wt, wd, ht};
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        wr_en    <= 1'b1;
        wr_index <= order[i];
        wr_data  <= data[i];
        @(posedge clk);
        sb.set_reg(order[i], data[i]);
      end
    end
    wr_en <= 1'b0;
    layouts++;
  endtask

  // Valid is left high on return so that a following query can go out back to back.
  task automatic send_cell(input logic [CELL_W-1:0] idx);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_query(idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Pixel register value with random junk in the bits above the 12 that count.
  function automatic logic [PACK_W-1:0] pixel_word();
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 4095;
      2: v = $urandom_range(0, 20);
      default: v = $urandom_range(0, 4095);
    endcase
    return {COORD_W'($urandom), COORD_W'(v)};
  endfunction

  initial begin
    int n_items, span, total, rows, top_idx;
    logic [PACK_W-1:0] cc, wt;
    logic [3:0] mask;
    logic [CELL_W-1:0] idx;
    sb = new();
    n_items = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Default layout straight out of reset: a single full-screen cell.
    send_cell(0);
    send_cell(1);
    send_cell(127);
    drain();

    // Largest layout at the largest screen.
    load_layout(24'hFFFFFF, 24'hFFFFFF, 24'hFFF, 24'hFFF, 4'hF);
    send_cell(0);
    send_cell(14);
    send_cell(15);
    send_cell(89);
    send_cell(90);
    send_cell(127);
    drain();

    // Row 0 empty: nothing exists, whatever the later nibbles hold.
    load_layout(24'h555550, 24'h123456, 24'd640, 24'd480, 4'hF);
    send_cell(0);
    send_cell(5);
    drain();

    // Weights zero over the listed rows, non-zero past the end of the list.
    load_layout(24'h000321, 24'hFFF000, 24'd7, 24'd100, 4'hF);
    send_cell(0);
    send_cell(1);
    send_cell(2);
    send_cell(3);
    send_cell(5);
    send_cell(6);
    drain();

    // Zero-sized screen.
    load_layout(24'h111111, 24'h000001, 24'hFFF000, 24'hABC000, 4'hF);
    send_cell(0);
    send_cell(5);
    send_cell(6);
    drain();

    // An empty third row cuts the list short.
    load_layout(24'h00F0FF, 24'h00F0F3, 24'd1000, 24'd999, 4'hF);
    send_cell(29);
    send_cell(30);
    send_cell(42);
    send_cell(85);
    drain();

    while (n_items < QUERY_COUNT) begin
      idle_on = (n_items >= QUERY_COUNT - CALM_TAIL) ? 1'b0 : ($urandom_range(0, 3) != 0);

      // Mostly well-formed row lists of varying depth, with junk past the end marker.
      rows = $urandom_range(0, 12);
      if (rows > MAX_ROWS) rows = $urandom_range(3, MAX_ROWS);
      cc = PACK_W'($urandom_range(0, 24'hFFFFFF));
      for (int r = 0; r < MAX_ROWS; r++) begin
        if (r < rows) cc[r*NIB_W +: NIB_W] = NIB_W'($urandom_range(1, 15));
        else if (r == rows) cc[r*NIB_W +: NIB_W] = '0;
      end
      if ($urandom_range(0, 7) == 0) cc = PACK_W'($urandom_range(0, 24'hFFFFFF));
      wt = PACK_W'($urandom_range(0, 24'hFFFFFF));
      case ($urandom_range(0, 5))
        0: for (int r = 0; r < rows; r++) wt[r*NIB_W +: NIB_W] = '0;
        1: wt = 24'hFFFFFF;
        default: ;
      endcase
      mask = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'hF;
      load_layout(cc, wt, pixel_word(), pixel_word(), mask);

      total = sb.cell_total();
      top_idx = (total + 1 > 127) ? 127 : total + 1;
      span = $urandom_range(20, 80);
      for (int i = 0; i < span; i++) begin
        if ($urandom_range(0, 3) == 0) idx = CELL_W'($urandom_range(0, 127));
        else idx = CELL_W'($urandom_range(0, top_idx));
        send_cell(idx);
        n_items++;
        if (idle_on && $urandom_range(0, 60) == 0) drain();
      end
      drain();
    end

    repeat (80) @(posedge clk);
    if (sb.outstanding() != 0) begin
      sb.report_mismatch($sformatf("%0d rectangles never arrived", sb.outstanding()));
    end
    $display("Checked %0d cell queries over %0d register layouts; %0d named an existing cell.",
             sb.queries, layouts, sb.hits);
    $display("Stimulus mixed valid and stall bursts with gap-free stretches; %0d mismatches.",
             sb.errors);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/wrtr_pkg.sv
src/wrtr_cfg.sv
src/wrtr_div.sv
src/weighted_row_tile_rect_core.sv
dv/weighted_row_tile_rect_core_test.sv
